FILE: rtl/text_mode_terminal_writer_top_defines.svh
// assertion macros shared by the checker files
`ifndef TEXT_MODE_TERMINAL_WRITER_TOP_DEFINES_SVH
`define TEXT_MODE_TERMINAL_WRITER_TOP_DEFINES_SVH

// concurrent assertion on an explicit clock and active-low reset
`define TMTW_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tmtw check failed");

// concurrent assertion on the block clock and reset
`define TMTW_ASSERT(label, prop) `TMTW_ASSERT_CLK(label, i_clk, i_rst_n, prop)

`endif

FILE: rtl/tmtw_pkg.sv
package tmtw_pkg;

    // terminal command codes
    typedef enum logic [3:0] {
        CMD_PUT_CHAR     = 4'd0,
        CMD_SET_COLOR    = 4'd1,
        CMD_CLEAR        = 4'd2,
        CMD_CLEAR_BEFORE = 4'd3,
        CMD_CLEAR_FROM   = 4'd4,
        CMD_SET_CURSOR   = 4'd5,
        CMD_BACKSPACE    = 4'd6,
        CMD_READ         = 4'd7,
        CMD_WRITE_CELL   = 4'd8
    } t_cmd;

    // controller states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_COPY_RD,
        S_COPY_WR,
        S_RD_WAIT,
        S_DONE
    } t_state;

    // datapath operations for one cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_PUT,
        OP_COLOR,
        OP_HOME,
        OP_SET_CURSOR,
        OP_BACKSPACE,
        OP_WRITE_CELL,
        OP_READ,
        OP_FILL,
        OP_COPY_RD,
        OP_COPY_WR
    } t_dp_op;

    // sweep pointer setup
    typedef enum logic [1:0] {
        SW_NONE,
        SW_ALL,
        SW_BEFORE,
        SW_FROM
    } t_sweep;

    typedef struct packed {
        logic   capture;
        t_dp_op op;
        t_sweep sweep;
        logic   load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic newline;
        logic col_last;
        logic row_last;
        logic sweep_done;
        logic copy_done;
    } t_dp_sts;

    localparam logic [15:0] RESET_CELL   = 16'h0720;
    localparam logic [7:0]  RESET_COLOR  = 8'h07;
    localparam logic [7:0]  BLANK_CHAR   = 8'h20;
    localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;

endpackage

FILE: rtl/text_mode_terminal_writer_top.sv
// Text-mode terminal engine: a COLUMNS x ROWS store of 16-bit cells (color in the
// high byte, character in the low byte), a cursor and a current color.
// Input channel i_valid/o_ready carries one command word per transfer; the output
// channel o_valid/i_ready returns one result word per command with the cursor
// after the command and, for a read in range, the cell contents (zero otherwise).
// Put char, color, cursor, backspace and write cell pass through the execute and
// done states; read cell adds a wait state for the registered store read. For
// back-to-back commands the controller takes the next word in the same cycle it
// loads the result register. Clears walk the store one cell per cycle.
// A scroll copies each cell through the single store read port, a read state then
// a write state per cell, then blanks the last row.
// After reset the store is swept to blank 0x0720 cells with o_ready low; the
// cursor starts at home and the color at 0x07.
// A stalled receiver holds the result word; one more word may be accepted and
// worked on, and it waits in the controller until the result register frees up.
module text_mode_terminal_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_command,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_attr_color,
    input  logic [6:0]  i_col_in,
    input  logic [4:0]  i_row_in,
    input  logic [10:0] i_cell_addr,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row,
    output logic [10:0] o_cursor_offset,
    output logic [15:0] o_cell_data
);
    import tmtw_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer
    tmtw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    // cursor, color, sweep pointer and cell store
    tmtw_dp #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .i_command       (i_command),
        .i_char_code     (i_char_code),
        .i_attr_color    (i_attr_color),
        .i_col_in        (i_col_in),
        .i_row_in        (i_row_in),
        .i_cell_addr     (i_cell_addr),
        .o_cursor_col    (o_cursor_col),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_offset (o_cursor_offset),
        .o_cell_data     (o_cell_data)
    );

endmodule

FILE: rtl/tmtw_ram.sv
module tmtw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/tmtw_ctrl.sv
module tmtw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  tmtw_pkg::t_dp_sts i_sts,
    output tmtw_pkg::t_dp_cmd o_cmd
);
    import tmtw_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    logic   out_free;
    logic   ready;

    assign out_free = !r_out_vld || i_ready;

    // state register and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (i_sts.sweep_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (i_sts.cmd)
                    CMD_PUT_CHAR: begin
                        if ((i_sts.newline || i_sts.col_last) && i_sts.row_last) begin
                            n_state = S_COPY_RD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    CMD_CLEAR, CMD_CLEAR_BEFORE, CMD_CLEAR_FROM: n_state = S_FILL;
                    CMD_READ: n_state = S_RD_WAIT;
                    default:  n_state = S_DONE;
                endcase
            end
            S_FILL: begin
                if (i_sts.sweep_done) n_state = S_DONE;
            end
            S_COPY_RD: begin
                n_state = i_sts.copy_done ? S_FILL : S_COPY_WR;
            end
            S_COPY_WR: n_state = S_COPY_RD;
            S_RD_WAIT: n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = i_valid ? S_EXEC : S_IDLE;
            end
        endcase
    end

    // datapath commands and handshake
    always_comb begin
        ready          = 1'b0;
        o_cmd.op       = OP_NONE;
        o_cmd.sweep    = SW_NONE;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_INIT: begin
                if (!i_sts.sweep_done) o_cmd.op = OP_INIT;
            end
            S_IDLE: ready = 1'b1;
            S_EXEC: begin
                unique case (i_sts.cmd)
                    CMD_PUT_CHAR: begin
                        o_cmd.op = OP_PUT;
                        o_cmd.sweep = SW_ALL;
                    end
                    CMD_SET_COLOR: o_cmd.op = OP_COLOR;
                    CMD_CLEAR: begin
                        o_cmd.op    = OP_HOME;
                        o_cmd.sweep = SW_ALL;
                    end
                    CMD_CLEAR_BEFORE: o_cmd.sweep = SW_BEFORE;
                    CMD_CLEAR_FROM:   o_cmd.sweep = SW_FROM;
                    CMD_SET_CURSOR:   o_cmd.op = OP_SET_CURSOR;
                    CMD_BACKSPACE:    o_cmd.op = OP_BACKSPACE;
                    CMD_READ:         o_cmd.op = OP_READ;
                    CMD_WRITE_CELL:   o_cmd.op = OP_WRITE_CELL;
                    default:          o_cmd.op = OP_NONE;
                endcase
            end
            S_FILL: begin
                if (!i_sts.sweep_done) o_cmd.op = OP_FILL;
            end
            S_COPY_RD: begin
                if (!i_sts.copy_done) o_cmd.op = OP_COPY_RD;
            end
            S_COPY_WR: o_cmd.op = OP_COPY_WR;
            S_RD_WAIT: o_cmd.op = OP_NONE;
            S_DONE: begin
                o_cmd.load_out = out_free;
                ready          = out_free;
            end
        endcase
        o_cmd.capture = ready && i_valid;
    end

    // result word stays until taken
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_vld = 1'b1;
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    assign o_ready = ready;
    assign o_valid = r_out_vld;

endmodule

FILE: rtl/tmtw_dp.sv
module tmtw_dp #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tmtw_pkg::t_dp_cmd i_cmd,
    output tmtw_pkg::t_dp_sts o_sts,
    input  logic [3:0]        i_command,
    input  logic [7:0]        i_char_code,
    input  logic [7:0]        i_attr_color,
    input  logic [6:0]        i_col_in,
    input  logic [4:0]        i_row_in,
    input  logic [10:0]       i_cell_addr,
    output logic [6:0]        o_cursor_col,
    output logic [4:0]        o_cursor_row,
    output logic [10:0]       o_cursor_offset,
    output logic [15:0]       o_cell_data
);
    import tmtw_pkg::*;

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int CELL_AW    = $clog2(CELLS);
    localparam int CNT_W      = $clog2(CELLS + 1);
    localparam int ADDR_CMP_W = (CNT_W > 11) ? CNT_W : 11;

    // latched command word
    t_cmd        r_cmd;
    logic [7:0]  r_char;
    logic [7:0]  r_attr;
    logic [6:0]  r_col_in;
    logic [4:0]  r_row_in;
    logic [10:0] r_addr;

    // terminal state and sweep pointer
    logic [6:0]       r_col, n_col;
    logic [4:0]       r_row, n_row;
    logic [7:0]       r_color, n_color;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic [CNT_W-1:0] r_end, n_end;

    // result registers
    logic [6:0]  r_out_col;
    logic [4:0]  r_out_row;
    logic [10:0] r_out_off;
    logic [15:0] r_out_data;

    logic [CELL_AW-1:0] cur_idx;
    logic [CELL_AW-1:0] bs_idx;
    logic [CELL_AW-1:0] wc_idx;
    logic               newline;
    logic               col_last;
    logic               row_last;
    logic               wc_in_range;
    logic               addr_in_range;
    logic [15:0]        blank;

    logic               wr_en;
    logic [CELL_AW-1:0] wr_addr;
    logic [15:0]        wr_data;
    logic               rd_en;
    logic [CELL_AW-1:0] rd_addr;
    logic [15:0]        rd_data;

    // cell index arithmetic
    assign cur_idx       = CELL_AW'(int'(r_row) * COLUMNS + int'(r_col));
    assign bs_idx        = (cur_idx == '0) ? '0 : cur_idx - CELL_AW'(1);
    assign wc_idx        = CELL_AW'(int'(r_row_in) * COLUMNS + int'(r_col_in));
    assign newline       = (r_char == NEWLINE_CHAR);
    assign col_last      = (r_col == 7'(COLUMNS - 1));
    assign row_last      = (r_row == 5'(ROWS - 1));
    assign wc_in_range   = (r_col_in < 7'(COLUMNS)) && (r_row_in < 5'(ROWS));
    assign addr_in_range = ADDR_CMP_W'(r_addr) < ADDR_CMP_W'(CELLS);
    assign blank         = {r_color, BLANK_CHAR};

    // status to the controller
    assign o_sts.cmd        = r_cmd;
    assign o_sts.newline    = newline;
    assign o_sts.col_last   = col_last;
    assign o_sts.row_last   = row_last;
    assign o_sts.sweep_done = (r_ptr == r_end);
    assign o_sts.copy_done  = (r_ptr == CNT_W'(CELLS - COLUMNS));

    // capture the accepted command word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd    <= t_cmd'(i_command);
            r_char   <= i_char_code;
            r_attr   <= i_attr_color;
            r_col_in <= i_col_in;
            r_row_in <= i_row_in;
            r_addr   <= i_cell_addr;
        end
    end

    // cursor and color updates
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_color = r_color;
        unique case (i_cmd.op)
            OP_PUT: begin
                if (newline || col_last) begin
                    n_col = '0;
                    if (!row_last) n_row = r_row + 5'd1;
                end else begin
                    n_col = r_col + 7'd1;
                end
            end
            OP_COLOR: n_color = r_attr;
            OP_HOME: begin
                n_col = '0;
                n_row = '0;
            end
            OP_SET_CURSOR: begin
                n_col = (r_col_in >= 7'(COLUMNS)) ? 7'(COLUMNS - 1) : r_col_in;
                n_row = (r_row_in >= 5'(ROWS)) ? 5'(ROWS - 1) : r_row_in;
            end
            OP_BACKSPACE: begin
                if (r_col != '0) begin
                    n_col = r_col - 7'd1;
                end else if (r_row != '0) begin
                    n_row = r_row - 5'd1;
                    n_col = 7'(COLUMNS - 1);
                end
            end
            default: begin
                n_col = r_col;
            end
        endcase
    end

    // sweep pointer: load a range or step through it
    always_comb begin
        n_ptr = r_ptr;
        n_end = r_end;
        unique case (i_cmd.sweep)
            SW_ALL: begin
                n_ptr = '0;
                n_end = CNT_W'(CELLS);
            end
            SW_BEFORE: begin
                n_ptr = '0;
                n_end = CNT_W'(cur_idx);
            end
            SW_FROM: begin
                n_ptr = CNT_W'(cur_idx);
                n_end = CNT_W'(CELLS);
            end
            SW_NONE: begin
                if (i_cmd.op == OP_INIT || i_cmd.op == OP_FILL || i_cmd.op == OP_COPY_WR) begin
                    n_ptr = r_ptr + CNT_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_color <= RESET_COLOR;
            r_ptr   <= '0;
            r_end   <= CNT_W'(CELLS);
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_color <= n_color;
            r_ptr   <= n_ptr;
            r_end   <= n_end;
        end
    end

    // cell store ports
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cur_idx;
        wr_data = blank;
        rd_en   = 1'b0;
        rd_addr = CELL_AW'(r_addr);
        unique case (i_cmd.op)
            OP_INIT: begin
                wr_en   = 1'b1;
                wr_addr = CELL_AW'(r_ptr);
                wr_data = RESET_CELL;
            end
            OP_PUT: begin
                wr_en   = !newline;
                wr_data = {r_color, r_char};
            end
            OP_BACKSPACE: begin
                wr_en   = 1'b1;
                wr_addr = bs_idx;
            end
            OP_WRITE_CELL: begin
                wr_en   = wc_in_range;
                wr_addr = wc_idx;
                wr_data = {r_attr, r_char};
            end
            OP_FILL: begin
                wr_en   = 1'b1;
                wr_addr = CELL_AW'(r_ptr);
            end
            OP_COPY_WR: begin
                wr_en   = 1'b1;
                wr_addr = CELL_AW'(r_ptr);
                wr_data = rd_data;
            end
            OP_READ: rd_en = 1'b1;
            OP_COPY_RD: begin
                rd_en   = 1'b1;
                rd_addr = CELL_AW'(r_ptr + CNT_W'(COLUMNS));
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    tmtw_ram #(
        .WIDTH(16),
        .DEPTH(CELLS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_col  <= r_col;
            r_out_row  <= r_row;
            r_out_off  <= 11'(cur_idx);
            r_out_data <= (r_cmd == CMD_READ && addr_in_range) ? rd_data : '0;
        end
    end

    assign o_cursor_col    = r_out_col;
    assign o_cursor_row    = r_out_row;
    assign o_cursor_offset = r_out_off;
    assign o_cell_data     = r_out_data;

endmodule

FILE: rtl/tmtw_checker.sv
`include "text_mode_terminal_writer_top_defines.svh"

module tmtw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [6:0]  o_cursor_col,
    input logic [4:0]  o_cursor_row,
    input logic [10:0] o_cursor_offset,
    input logic [15:0] o_cell_data
);

    // a stalled result word holds
    `TMTW_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_cursor_offset) && $stable(o_cell_data))

    // reported cursor stays on the screen
    `TMTW_ASSERT(a_cursor_range, o_valid |-> (o_cursor_col < 7'(COLUMNS)) && (o_cursor_row < 5'(ROWS)))

    // offset matches row and column
    `TMTW_ASSERT(a_cursor_offset, o_valid |-> o_cursor_offset == 11'(int'(o_cursor_row) * COLUMNS + int'(o_cursor_col)))

    // one word worked on at a time: busy right after an accept
    `TMTW_ASSERT(a_busy_after_accept, i_valid && o_ready |=> !o_ready)

endmodule

bind text_mode_terminal_writer_top tmtw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_tmtw_checker (.*);
